// ===== sv/signed_width_alu_overflow_unit_assert.svh =====
// Assertion macros used by the signed width ALU top level.
// No dependencies.
`ifndef SIGNED_WIDTH_ALU_OVERFLOW_UNIT_ASSERT_SVH
`define SIGNED_WIDTH_ALU_OVERFLOW_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define SWA_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define SWA_ASSERT_NXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== sv/swa_pkg.sv =====
// Package for the signed width ALU: payload types, opcodes, constants.
// No dependencies.
package swa_pkg;
    localparam int unsigned DefMaxWidth = 64;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_FACT = 3'd4
    } op_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [63:0] operand_a;
        logic [63:0] operand_b;
    } swa_in_t;

    typedef struct packed {
        logic signed [63:0] result;
        logic               overflow;
    } swa_out_t;

    typedef struct packed {
        logic start_mul;
        logic start_div;
    } swa_ctl_t;
endpackage

// ===== sv/swa_muldiv.sv =====
// Shared shift-add multiplier / restoring divider, one bit per cycle.
// Depends on swa_pkg.
module swa_muldiv
    import swa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  swa_ctl_t    ctl,
    input  logic [63:0] x,
    input  logic [63:0] y,
    output logic        done,
    output logic [127:0] prod,
    output logic [63:0] quot
);
    logic [127:0] acc_reg, acc_next;
    logic [63:0]  y_reg, y_next;
    logic [63:0]  q_reg, q_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         div_reg, div_next;
    logic         done_reg, done_next;
    logic [64:0]  trial;
    logic [127:0] sh;

    always_comb
    begin
        acc_next  = acc_reg;
        y_next    = y_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        // remainder lives in the upper half; next dividend bit enters at bit 64
        sh        = {acc_reg[126:64], q_reg[63], 64'd0};
        trial     = {1'b0, sh[127:64]} - {1'b0, y_reg};
        if (ctl.start_mul || ctl.start_div)
        begin
            busy_next = 1'b1;
            div_next  = ctl.start_div;
            cnt_next  = 7'd0;
            y_next    = y;
            acc_next  = ctl.start_div ? 128'd0 : {64'd0, x};
            q_next    = x;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                if (!trial[64])
                    acc_next = {trial[63:0], sh[63:0]};
                else
                    acc_next = sh;
                q_next = {q_reg[62:0], ~trial[64]};
            end
            else
            begin
                acc_next = {1'b0, acc_reg[127:65],
                            acc_reg[64] ^ 1'b0, acc_reg[63:1]};
                if (acc_reg[0])
                    acc_next[127:63] = {1'b0, acc_reg[127:64]} + {1'b0, y_reg};
                else
                    acc_next[127:63] = {1'b0, acc_reg[127:64]};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            div_reg  <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            div_reg  <= div_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        y_reg   <= y_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;
    assign quot = q_reg;
endmodule

// ===== sv/signed_width_alu_overflow_unit.sv =====
// Top level of the signed width ALU: sequencer and width register.
// Depends on swa_pkg, swa_muldiv and the assertion header.
// Path to result strobe: add/sub go from S_ARITH to S_DONE; mul/div wait in S_MULW/S_DIVW;
// factorial runs one multiply per S_FSTEP/S_FWAIT pass, up to 21 multiplies at 64 bits.
// Throughput: one item at a time; busy drops as the result strobe rises.
// Every multiply and divide goes through the shared bit-serial multiply/divide unit.
// Reset (rst_n low, asynchronous) sets width to MAX_WIDTH and idles the block.
`include "signed_width_alu_overflow_unit_assert.svh"
module signed_width_alu_overflow_unit
    import swa_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = DefMaxWidth
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  swa_in_t  in_item,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic [6:0] cfg_data,
    output logic     out_strobe,
    output swa_out_t out_item
);
    typedef enum logic [2:0] {S_IDLE, S_ARITH, S_MULW, S_DIVW, S_FSTEP, S_FWAIT, S_DONE} st_t;

    st_t          st_reg;
    logic [6:0]   width_reg;
    logic [6:0]   n;
    logic [63:0]  mask, maxv;
    logic [2:0]   op_reg;
    logic [63:0]  a_reg, b_reg, acc_reg, i_reg;
    logic         neg_reg;
    logic [63:0]  res_reg;
    logic         ovf_reg;
    logic         strobe_reg;
    logic [63:0]  a_s, b_s, ma, mb;
    swa_ctl_t     ctl;
    logic [63:0]  mx, my;
    logic         md_done;
    logic [127:0] prod;
    logic [63:0]  quot;
    logic [63:0]  s_sum, s_dif;
    logic [63:0]  cand;

    function automatic logic [63:0] sext(input logic [63:0] v, input logic [6:0] w);
        logic [63:0] m;
        logic [63:0] lo;
        begin
            m  = (w >= 7'd64) ? {64{1'b1}} : ((64'd1 << w) - 64'd1);
            lo = v & m;
            if (w < 7'd64 && lo[w[5:0] - 6'd1])
                lo = lo | ~m;
            sext = lo;
        end
    endfunction

    always_comb
    begin
        n = width_reg;
        if (n < 7'd2)
            n = 7'd2;
        if ({25'd0, n} > MAX_WIDTH)
            n = MAX_WIDTH[6:0];
        if (n > 7'd64)
            n = 7'd64;
        mask = (n >= 7'd64) ? {64{1'b1}} : ((64'd1 << n) - 64'd1);
        maxv = mask >> 1;
        a_s  = sext(in_item.operand_a, n);
        b_s  = sext(in_item.operand_b, n);
        ma   = a_reg[63] ? -a_reg : a_reg;
        mb   = b_reg[63] ? -b_reg : b_reg;
        s_sum = a_reg + b_reg;
        s_dif = a_reg - b_reg;
        cand  = neg_reg ? -prod[63:0] : prod[63:0];
    end

    always_comb
    begin
        ctl = '0;
        mx  = ma;
        my  = mb;
        if (st_reg == S_ARITH && op_reg == OP_MUL)
            ctl.start_mul = 1'b1;
        if (st_reg == S_ARITH && op_reg == OP_DIV && b_reg != 64'd0)
            ctl.start_div = 1'b1;
        if (st_reg == S_FSTEP)
        begin
            ctl.start_mul = 1'b1;
            mx = acc_reg;
            my = i_reg;
        end
    end

    swa_muldiv u_md (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (ctl),
        .x    (mx),
        .y    (my),
        .done (md_done),
        .prod (prod),
        .quot (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_IDLE;
            width_reg  <= MAX_WIDTH[6:0];
            strobe_reg <= 1'b0;
            op_reg     <= OP_ADD;
            a_reg      <= 64'd0;
            b_reg      <= 64'd0;
            acc_reg    <= 64'd0;
            i_reg      <= 64'd0;
            neg_reg    <= 1'b0;
            res_reg    <= 64'd0;
            ovf_reg    <= 1'b0;
            out_item   <= '0;
        end
        else
        begin
            strobe_reg <= (st_reg == S_DONE);
            if (cfg_valid && cfg_ready)
                width_reg <= cfg_data;
            case (st_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg  <= in_item.operation;
                        a_reg   <= a_s;
                        b_reg   <= b_s;
                        neg_reg <= a_s[63] ^ b_s[63];
                        st_reg  <= S_ARITH;
                    end
                end
                S_ARITH:
                begin
                    case (op_reg)
                        OP_ADD:
                        begin
                            res_reg <= s_sum;
                            ovf_reg <= ((a_reg ^ s_sum) & (b_reg ^ s_sum)) >> 63 != 64'd0
                                       || sext(s_sum, n) != s_sum;
                            st_reg  <= S_DONE;
                        end
                        OP_SUB:
                        begin
                            res_reg <= s_dif;
                            ovf_reg <= ((a_reg ^ b_reg) & (a_reg ^ s_dif)) >> 63 != 64'd0
                                       || sext(s_dif, n) != s_dif;
                            st_reg  <= S_DONE;
                        end
                        OP_MUL:
                            st_reg <= S_MULW;
                        OP_DIV:
                        begin
                            if (b_reg == 64'd0)
                            begin
                                res_reg <= 64'd0;
                                ovf_reg <= 1'b1;
                                st_reg  <= S_DONE;
                            end
                            else
                                st_reg <= S_DIVW;
                        end
                        OP_FACT:
                        begin
                            if (a_reg[63])
                            begin
                                res_reg <= 64'd0;
                                ovf_reg <= 1'b1;
                                st_reg  <= S_DONE;
                            end
                            else if (a_reg == 64'd0)
                            begin
                                res_reg <= 64'd1;
                                ovf_reg <= 1'b0;
                                st_reg  <= S_DONE;
                            end
                            else
                            begin
                                acc_reg <= 64'd1;
                                i_reg   <= 64'd1;
                                neg_reg <= 1'b0;
                                st_reg  <= S_FSTEP;
                            end
                        end
                        default:
                        begin
                            res_reg <= 64'd0;
                            ovf_reg <= 1'b0;
                            st_reg  <= S_DONE;
                        end
                    endcase
                end
                S_MULW:
                begin
                    if (md_done)
                    begin
                        res_reg <= cand;
                        ovf_reg <= prod[127:64] != 64'd0 || prod[63:0] >
                                   ((neg_reg && prod[63:0] != 64'd0) ? maxv + 64'd1 : maxv);
                        st_reg  <= S_DONE;
                    end
                end
                S_DIVW:
                begin
                    if (md_done)
                    begin
                        res_reg <= (neg_reg && quot != 64'd0) ? -quot : quot;
                        ovf_reg <= !(neg_reg && quot != 64'd0) && quot > maxv;
                        st_reg  <= S_DONE;
                    end
                end
                S_FWAIT:
                begin
                    if (md_done)
                    begin
                        acc_reg <= prod[63:0];
                        i_reg   <= i_reg + 64'd1;
                        if (prod[127:64] != 64'd0 || prod[63:0] > maxv)
                        begin
                            res_reg <= prod[63:0];
                            ovf_reg <= 1'b1;
                            st_reg  <= S_DONE;
                        end
                        else if (i_reg + 64'd1 > a_reg)
                        begin
                            res_reg <= prod[63:0];
                            ovf_reg <= 1'b0;
                            st_reg  <= S_DONE;
                        end
                        else
                            st_reg <= S_FSTEP;
                    end
                end
                S_FSTEP:
                    st_reg <= S_FWAIT;
                S_DONE:
                begin
                    out_item.result   <= sext(res_reg, n);
                    out_item.overflow <= ovf_reg;
                    st_reg            <= S_IDLE;
                end
                default:
                    st_reg <= S_IDLE;
            endcase
        end
    end

    assign busy       = (st_reg != S_IDLE);
    assign cfg_ready  = (st_reg == S_IDLE) && !start;
    assign out_strobe = strobe_reg;

    `SWA_ASSERT_NXT(a_busy_after_start, clk, rst_n, start && !busy, busy, "start not taken")
    `SWA_ASSERT_NXT(a_strobe_idle, clk, rst_n, out_strobe && !start, !busy, "busy after result")
    `SWA_ASSERT_IMP(a_strobe_one, clk, rst_n, out_strobe, !$past(out_strobe), "double strobe")
endmodule

// ===== test/signed_width_alu_overflow_unit_tb.sv =====
// Self-checking testbench for signed_width_alu_overflow_unit: directed and random
// operations at several widths, checked against an exact-arithmetic predictor.
// Depends on swa_pkg and the signed_width_alu_overflow_unit RTL.
module signed_width_alu_overflow_unit_tb;
    import swa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {K_OP, K_WIDTH, K_DRAIN} job_kind_t;

    typedef struct {
        job_kind_t  kind;
        swa_in_t    item;
        logic [6:0] width;
        int         gap;
    } job_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    swa_in_t    in_item = '0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [6:0] cfg_data = '0;
    logic       out_strobe;
    swa_out_t   out_item;

    job_t       job_q[$];
    swa_out_t   expected_q[$];
    logic [6:0] width_reg = 7'd64;
    int         settle_cnt = 0;
    int         errors = 0;

    signed_width_alu_overflow_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_strobe(out_strobe),
        .out_item  (out_item)
    );

    always #5 clk = ~clk;

    function automatic logic signed [129:0] sign_in(logic [63:0] v, int n);
        logic [63:0] m;
        logic [63:0] low;
        m = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
        low = v & m;
        if (low[n-1])
        begin
            low = low | ~m;
        end
        return signed'({{66{low[63]}}, low});
    endfunction

    function automatic swa_out_t alu_predict(swa_in_t it, logic [6:0] wreg);
        int                    n;
        logic signed [129:0]   a;
        logic signed [129:0]   b;
        logic signed [129:0]   x;
        logic signed [129:0]   hi_lim;
        logic signed [129:0]   lo_lim;
        logic signed [129:0]   i;
        logic                  ovf;
        logic                  forced;
        logic signed [129:0]   wrapped;
        swa_out_t              r;
        n = (wreg < 2) ? 2 : ((wreg > 64) ? 64 : int'(wreg));
        a = sign_in(it.operand_a, n);
        b = sign_in(it.operand_b, n);
        hi_lim = (130'sd1 <<< (n - 1)) - 130'sd1;
        lo_lim = -hi_lim - 130'sd1;
        ovf = 1'b0;
        forced = 1'b0;
        x = '0;
        case (it.operation)
            OP_ADD: x = a + b;
            OP_SUB: x = a - b;
            OP_MUL: x = a * b;
            OP_DIV:
            begin
                if (b == 0)
                begin
                    forced = 1'b1;
                    ovf = 1'b1;
                end
                else
                begin
                    x = a / b;
                end
            end
            OP_FACT:
            begin
                forced = 1'b1;
                if (a < 0)
                begin
                    ovf = 1'b1;
                end
                else
                begin
                    x = 130'sd1;
                    for (i = 130'sd1; i <= a && !ovf; i++)
                    begin
                        x = x * i;
                        if (x > hi_lim)
                        begin
                            ovf = 1'b1;
                        end
                    end
                end
            end
            default: forced = 1'b1;
        endcase
        if (!forced && (x > hi_lim || x < lo_lim))
        begin
            ovf = 1'b1;
        end
        wrapped = sign_in(x[63:0], n);
        r.result = wrapped[63:0];
        r.overflow = ovf;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s at %0t: got %h expected %h", what, $realtime, got, want);
        errors++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        logic s_n;
        logic cv_n;
        if (!rst_n)
        begin
            start <= 1'b0;
            cfg_valid <= 1'b0;
        end
        else
        begin
            s_n = start;
            cv_n = cfg_valid;
            if (start && !busy)
            begin
                expected_q.push_back(alu_predict(in_item, width_reg));
                s_n = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                width_reg = cfg_data;
                cv_n = 1'b0;
            end
            if (expected_q.size() == 0 && !start && !cfg_valid)
            begin
                settle_cnt++;
            end
            else
            begin
                settle_cnt = 0;
            end
            if (!s_n && !cv_n && job_q.size() > 0)
            begin
                if (job_q[0].gap > 0)
                begin
                    job_q[0].gap--;
                end
                else if (job_q[0].kind == K_OP)
                begin
                    in_item <= job_q[0].item;
                    s_n = 1'b1;
                    void'(job_q.pop_front());
                end
                else if (settle_cnt >= 8)
                begin
                    if (job_q[0].kind == K_WIDTH)
                    begin
                        cfg_data <= job_q[0].width;
                        cv_n = 1'b1;
                    end
                    void'(job_q.pop_front());
                end
            end
            start <= s_n;
            cfg_valid <= cv_n;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        swa_out_t want;
        if (rst_n && out_strobe)
        begin
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected result", out_item.result, '0);
            end
            else
            begin
                want = expected_q.pop_front();
                if (out_item.result !== want.result)
                begin
                    report_mismatch("result", out_item.result, want.result);
                end
                if (out_item.overflow !== want.overflow)
                begin
                    report_mismatch("overflow", 64'(out_item.overflow), 64'(want.overflow));
                end
            end
        end
    end

    task automatic add_op(logic [2:0] op, logic [63:0] a, logic [63:0] b, int gap);
        job_t j;
        j.kind = K_OP;
        j.item.operation = op;
        j.item.operand_a = a;
        j.item.operand_b = b;
        j.width = '0;
        j.gap = gap;
        job_q.push_back(j);
    endtask

    task automatic add_ctl(job_kind_t kind, logic [6:0] w);
        job_t j;
        j.kind = kind;
        j.item = '0;
        j.width = w;
        j.gap = 0;
        job_q.push_back(j);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pick_operand(int n);
        logic [63:0] hi;
        hi = (n >= 64) ? 64'h7FFF_FFFF_FFFF_FFFF : ((64'd1 << (n - 1)) - 64'd1);
        case ($urandom_range(0, 5))
            0: return hi;
            1: return ~hi;
            2: return 64'($urandom_range(0, 40)) ^ (rand64() & ~hi & ~(hi << 1));
            3: return -64'($urandom_range(1, 40));
            4: return rand64() >> $urandom_range(0, 63);
            default: return rand64();
        endcase
    endfunction

    initial
    begin
        int          n;
        int          gap;
        logic [2:0]  op;
        logic [6:0]  w;
        logic [6:0]  widths[8];
        widths = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd127, 7'd65, 7'd8, 7'd33};

        add_op(OP_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 64'd1, 0);
        add_op(OP_ADD, 64'h8000_0000_0000_0000, '1, 0);
        add_op(OP_SUB, 64'h8000_0000_0000_0000, 64'd1, 0);
        add_op(OP_SUB, 64'd5, 64'd9, 0);
        add_op(OP_MUL, 64'h8000_0000_0000_0000, '1, 0);
        add_op(OP_MUL, '1, 64'h8000_0000_0000_0000, 0);
        add_op(OP_MUL, 64'h4000_0000_0000_0000, '1, 0);
        add_op(OP_MUL, '0, 64'h8000_0000_0000_0000, 0);
        add_op(OP_DIV, 64'd7, '0, 0);
        add_op(OP_DIV, 64'h8000_0000_0000_0000, '1, 0);
        add_op(OP_DIV, -64'd7, 64'd2, 0);
        add_op(OP_DIV, 64'd1, -64'd3, 0);
        add_op(OP_FACT, -64'd1, '0, 0);
        add_op(OP_FACT, '0, '1, 0);
        add_op(OP_FACT, 64'd20, '0, 0);
        add_op(OP_FACT, 64'd21, '0, 0);
        add_op(OP_FACT, 64'h7FFF_FFFF_FFFF_FFFF, '1, 0);
        add_op(3'd5, '1, '1, 0);
        add_op(3'd7, '1, '1, 0);
        add_op(3'd6, '0, '0, 0);
        add_ctl(K_WIDTH, 7'd8);
        add_op(OP_ADD, 64'hFFFF_FFFF_FFFF_FF7F, 64'h01, 0);
        add_op(OP_FACT, 64'h05, '0, 0);
        add_op(OP_FACT, 64'h06, '0, 0);
        add_op(OP_DIV, 64'h80, 64'hFF, 0);

        for (int ph = 0; ph < 16; ph++)
        begin
            w = (ph < 8) ? widths[ph] : 7'($urandom_range(0, 127));
            add_ctl(K_WIDTH, w);
            n = (w < 2) ? 2 : ((w > 64) ? 64 : int'(w));
            for (int k = 0; k < 25; k++)
            begin
                op = 3'($urandom_range(0, 7));
                if (op > 4 && $urandom_range(0, 2) != 0)
                begin
                    op = 3'($urandom_range(0, 3));
                end
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
                if (ph % 4 == 1)
                begin
                    gap = 0;
                end
                add_op(op, pick_operand(n), pick_operand(n), gap);
                if (k == 12 && ph % 3 == 0)
                begin
                    add_ctl(K_DRAIN, '0);
                end
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        wait (job_q.size() == 0 && !start && !cfg_valid && expected_q.size() == 0);
        repeat (50) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/swa_pkg.sv
sv/swa_muldiv.sv
sv/signed_width_alu_overflow_unit.sv
test/signed_width_alu_overflow_unit_tb.sv
